@@ sv/number_theoretic_transform_defines.svh @@
// assertion macros for the transform rtl
`ifndef NUMBER_THEORETIC_TRANSFORM_DEFINES_SVH
`define NUMBER_THEORETIC_TRANSFORM_DEFINES_SVH

// same-cycle implication, checked on clk, off during reset
`define NTT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define NTT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/ntt_pkg.sv @@
package ntt_pkg;

	localparam int LOG_MAX = 10;
	localparam int ADDR_W = LOG_MAX;
	localparam int DEPTH = 1 << LOG_MAX;
	localparam int DATA_W = 31;
	localparam int LG_W = $clog2(LOG_MAX + 1);
	localparam int CNT_W = $clog2(DATA_W + 1);

	typedef logic [DATA_W-1:0] resid_t;
	typedef logic [ADDR_W-1:0] addr_t;

	localparam resid_t PRIME = 31'd2013265921;
	localparam resid_t GEN = 31'd31;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_RUN = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	localparam logic CFG_INVERSE = 1'b0;
	localparam logic CFG_LOG_LENGTH = 1'b1;

endpackage

@@ sv/ntt_ram.sv @@
module ntt_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ sv/number_theoretic_transform.sv @@
// channel   direction  handshake                 payload
// cmd       in         cmd_valid / cmd_stall     op, index, value
// reply     out        reply_valid / reply_stall reply_kind, data
// cfg       in         cfg_we                    cfg_index, cfg_data
//
// write and unused requests reply straight from idle; reads pass a wait state (registered ram read)
// a transform runs n/2 * log n butterflies plus the root power, bit reversal and, in inverse
// mode, 1/n scaling; every product goes through the shared bit-serial multiplier
// arst_n clears the sequencer, config and reply register; the coefficient ram is not cleared
// cmd_stall is high while a request is in flight or the reply register cannot take a result
// a stalled reply holds, and the next request is taken in the cycle the reply drains
`include "number_theoretic_transform_defines.svh"

module number_theoretic_transform (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_stall,
	input  logic [1:0]             op,
	input  logic [9:0]             index,
	input  logic [30:0]            value,
	output logic                   reply_valid,
	input  logic                   reply_stall,
	output logic [1:0]             reply_kind,
	output logic [30:0]            data,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [3:0]             cfg_data
);

	// sequencer codes
	localparam logic [4:0] ST_IDLE    = 5'd0;
	localparam logic [4:0] ST_RD_WAIT = 5'd1;
	localparam logic [4:0] ST_PREP    = 5'd2;
	localparam logic [4:0] ST_POW     = 5'd3;
	localparam logic [4:0] ST_POW_A   = 5'd4;
	localparam logic [4:0] ST_POW_SQ  = 5'd5;
	localparam logic [4:0] ST_POW_B   = 5'd6;
	localparam logic [4:0] ST_ROOTS   = 5'd7;
	localparam logic [4:0] ST_ROOTS_B = 5'd8;
	localparam logic [4:0] ST_REV     = 5'd9;
	localparam logic [4:0] ST_REV_B   = 5'd10;
	localparam logic [4:0] ST_REV_C   = 5'd11;
	localparam logic [4:0] ST_REV_D   = 5'd12;
	localparam logic [4:0] ST_BF      = 5'd13;
	localparam logic [4:0] ST_BF_A    = 5'd14;
	localparam logic [4:0] ST_BF_B    = 5'd15;
	localparam logic [4:0] ST_BF_C    = 5'd16;
	localparam logic [4:0] ST_BF_D    = 5'd17;
	localparam logic [4:0] ST_BF_W    = 5'd18;
	localparam logic [4:0] ST_SC      = 5'd19;
	localparam logic [4:0] ST_SC_A    = 5'd20;
	localparam logic [4:0] ST_SC_B    = 5'd21;
	localparam logic [4:0] ST_DONE    = 5'd22;
	localparam logic [4:0] ST_MUL     = 5'd23;

	localparam int CW = ntt_pkg::ADDR_W + 1;

	logic [4:0]  state_q, ret_q;
	logic        inverse_mode_q;
	logic [3:0]  log_length_q;
	logic [ntt_pkg::LG_W-1:0] lg, st_q;

	// reply register
	logic        out_valid_q;
	logic [1:0]  out_kind_q;
	ntt_pkg::resid_t out_data_q;

	// working registers
	ntt_pkg::addr_t  i_q;
	logic [CW-1:0]   base_q, j_q;
	ntt_pkg::resid_t e_q, pw_q, sq_q, w_q, u_q, v_q, t_q;
	ntt_pkg::resid_t roots_q [ntt_pkg::LOG_MAX+1];

	// shared bit-serial multiplier
	ntt_pkg::resid_t mul_x_q, mul_y_q, mul_acc_q;
	logic [ntt_pkg::CNT_W-1:0] mul_cnt_q;
	logic        mul_start;
	ntt_pkg::resid_t mul_a, mul_b;
	logic [31:0] dbl, dbl_r, addv, add_r;

	// ram port
	logic            ram_we;
	ntt_pkg::addr_t  ram_waddr, ram_raddr;
	ntt_pkg::resid_t ram_wdata, ram_rdata;

	logic            out_free, accept, load_out;
	logic [1:0]      load_kind;
	ntt_pkg::resid_t load_data;
	ntt_pkg::addr_t  mask, idx, rev_j, a_addr, b_addr;
	logic [CW-1:0]   n_full, half, len, base_nxt;
	ntt_pkg::resid_t val_red, exp_fwd, exp_sel, inv_n, s_sum, d_dif;
	logic [31:0]     sum_w;
	logic            last_j;

	function automatic ntt_pkg::addr_t rev_bits(ntt_pkg::addr_t x);
		ntt_pkg::addr_t r;
		for (int k = 0; k < ntt_pkg::ADDR_W; k++) begin
			r[k] = x[ntt_pkg::ADDR_W-1-k];
		end
		return r;
	endfunction

	ntt_ram #(
		.WIDTH(ntt_pkg::DATA_W),
		.DEPTH(ntt_pkg::DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// length saturates at the store size
	assign lg = (log_length_q > 4'(ntt_pkg::LOG_MAX)) ? ntt_pkg::LG_W'(ntt_pkg::LOG_MAX)
		: ntt_pkg::LG_W'(log_length_q);
	assign n_full = CW'(1) << lg;
	assign mask = ntt_pkg::ADDR_W'(n_full - CW'(1));
	assign idx = index & mask;
	assign val_red = (value >= ntt_pkg::PRIME) ? value - ntt_pkg::PRIME : value;

	// root of order n is gen^((p-1)/n); its inverse is gen^((p-1) - (p-1)/n)
	assign exp_fwd = (ntt_pkg::PRIME - 31'd1) >> lg;
	assign exp_sel = inverse_mode_q ? (ntt_pkg::PRIME - 31'd1) - exp_fwd : exp_fwd;
	// n * ((p-1)/n) = p-1 = -1, so 1/n = p - (p-1)/n
	assign inv_n = ntt_pkg::PRIME - exp_fwd;

	assign rev_j = rev_bits(i_q) >> (ntt_pkg::LG_W'(ntt_pkg::ADDR_W) - lg);

	// butterfly addressing
	assign half = CW'(1) << (st_q - ntt_pkg::LG_W'(1));
	assign len = CW'(1) << st_q;
	assign a_addr = ntt_pkg::ADDR_W'(base_q + j_q);
	assign b_addr = ntt_pkg::ADDR_W'(base_q + j_q + half);
	assign base_nxt = base_q + len;
	assign last_j = (j_q + CW'(1)) == half;

	assign sum_w = {1'b0, u_q} + {1'b0, mul_acc_q};
	assign s_sum = (sum_w >= {1'b0, ntt_pkg::PRIME}) ? 31'(sum_w - {1'b0, ntt_pkg::PRIME})
		: sum_w[30:0];
	assign d_dif = (u_q >= v_q) ? u_q - v_q : 31'({1'b0, u_q} + {1'b0, ntt_pkg::PRIME}
		- {1'b0, v_q});

	assign out_free = !out_valid_q || !reply_stall;
	assign cmd_stall = !(state_q == ST_IDLE && out_free);
	assign accept = cmd_valid && !cmd_stall;

	assign reply_valid = out_valid_q;
	assign reply_kind = out_kind_q;
	assign data = out_data_q;

	// ram controls and multiplier launch per state
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = i_q;
		ram_wdata = ram_rdata;
		ram_raddr = i_q;
		mul_start = 1'b0;
		mul_a = pw_q;
		mul_b = sq_q;
		load_out = 1'b0;
		load_kind = ntt_pkg::OP_WRITE;
		load_data = '0;
		unique case (state_q)
			ST_IDLE: begin
				ram_raddr = idx;
				ram_waddr = idx;
				ram_wdata = val_red;
				if (accept) begin
					ram_we = (op == ntt_pkg::OP_WRITE);
					load_out = (op != ntt_pkg::OP_READ) && (op != ntt_pkg::OP_RUN);
					load_kind = op;
				end
			end
			ST_RD_WAIT: begin
				load_out = 1'b1;
				load_kind = ntt_pkg::OP_READ;
				load_data = ram_rdata;
			end
			ST_POW: begin
				mul_start = (e_q != '0) && e_q[0];
			end
			ST_POW_SQ: begin
				mul_start = 1'b1;
				mul_a = sq_q;
			end
			ST_ROOTS: begin
				mul_start = (st_q != ntt_pkg::LG_W'(1));
				mul_b = pw_q;
			end
			ST_REV: ram_raddr = i_q;
			ST_REV_B: ram_raddr = rev_j;
			ST_REV_C: begin
				ram_we = 1'b1;
				ram_waddr = i_q;
				ram_wdata = ram_rdata;
			end
			ST_REV_D: begin
				ram_we = 1'b1;
				ram_waddr = rev_j;
				ram_wdata = t_q;
			end
			ST_BF: ram_raddr = b_addr;
			ST_BF_A: ram_raddr = a_addr;
			ST_BF_B: begin
				mul_start = 1'b1;
				mul_a = v_q;
				mul_b = w_q;
			end
			ST_BF_C: begin
				ram_we = 1'b1;
				ram_waddr = a_addr;
				ram_wdata = s_sum;
			end
			ST_BF_D: begin
				ram_we = 1'b1;
				ram_waddr = b_addr;
				ram_wdata = d_dif;
				mul_start = !last_j;
				mul_a = w_q;
				mul_b = roots_q[st_q];
			end
			ST_SC: ram_raddr = i_q;
			ST_SC_A: begin
				mul_start = 1'b1;
				mul_a = ram_rdata;
				mul_b = inv_n;
			end
			ST_SC_B: begin
				ram_we = 1'b1;
				ram_waddr = i_q;
				ram_wdata = mul_acc_q;
			end
			ST_DONE: begin
				load_out = out_free;
				load_kind = ntt_pkg::OP_RUN;
			end
			default: ;
		endcase
	end

	// multiplier step: acc = 2*acc + bit*y mod p, msb of x first
	always_comb begin
		dbl = {mul_acc_q, 1'b0};
		dbl_r = (dbl >= {1'b0, ntt_pkg::PRIME}) ? dbl - {1'b0, ntt_pkg::PRIME} : dbl;
		addv = dbl_r + (mul_x_q[ntt_pkg::DATA_W-1] ? {1'b0, mul_y_q} : 32'd0);
		add_r = (addv >= {1'b0, ntt_pkg::PRIME}) ? addv - {1'b0, ntt_pkg::PRIME} : addv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_cnt_q <= '0;
			mul_x_q <= '0;
			mul_y_q <= '0;
			mul_acc_q <= '0;
		end else if (mul_start) begin
			mul_cnt_q <= ntt_pkg::CNT_W'(ntt_pkg::DATA_W);
			mul_x_q <= mul_a;
			mul_y_q <= mul_b;
			mul_acc_q <= '0;
		end else if (mul_cnt_q != '0) begin
			mul_cnt_q <= mul_cnt_q - ntt_pkg::CNT_W'(1);
			mul_x_q <= mul_x_q << 1;
			mul_acc_q <= add_r[30:0];
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inverse_mode_q <= 1'b0;
			log_length_q <= 4'd10;
		end else if (cfg_we) begin
			if (cfg_index == ntt_pkg::CFG_INVERSE) begin
				inverse_mode_q <= cfg_data[0];
			end else begin
				log_length_q <= cfg_data;
			end
		end
	end

	// reply register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_kind_q <= '0;
			out_data_q <= '0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
			out_kind_q <= load_kind;
			out_data_q <= load_data;
		end else if (out_valid_q && !reply_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// per-stage roots, filled from the top stage down by squaring
	always_ff @(posedge clk) begin
		if (state_q == ST_ROOTS) begin
			roots_q[st_q] <= pw_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q <= ST_IDLE;
			st_q <= '0;
			i_q <= '0;
			base_q <= '0;
			j_q <= '0;
			e_q <= '0;
			pw_q <= '0;
			sq_q <= '0;
			w_q <= '0;
			u_q <= '0;
			v_q <= '0;
			t_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && op == ntt_pkg::OP_READ) begin
						state_q <= ST_RD_WAIT;
					end else if (accept && op == ntt_pkg::OP_RUN) begin
						state_q <= ST_PREP;
					end
				end
				ST_RD_WAIT: state_q <= ST_IDLE;
				ST_PREP: begin
					if (lg == '0) begin
						state_q <= ST_DONE;
					end else begin
						e_q <= exp_sel;
						pw_q <= 31'd1;
						sq_q <= ntt_pkg::GEN;
						state_q <= ST_POW;
					end
				end
				ST_POW: begin
					if (e_q == '0) begin
						st_q <= lg;
						state_q <= ST_ROOTS;
					end else if (e_q[0]) begin
						ret_q <= ST_POW_A;
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_POW_SQ;
					end
				end
				ST_POW_A: begin
					pw_q <= mul_acc_q;
					state_q <= ST_POW_SQ;
				end
				ST_POW_SQ: begin
					ret_q <= ST_POW_B;
					state_q <= ST_MUL;
				end
				ST_POW_B: begin
					sq_q <= mul_acc_q;
					e_q <= e_q >> 1;
					state_q <= ST_POW;
				end
				ST_ROOTS: begin
					if (st_q == ntt_pkg::LG_W'(1)) begin
						i_q <= '0;
						state_q <= ST_REV;
					end else begin
						ret_q <= ST_ROOTS_B;
						state_q <= ST_MUL;
					end
				end
				ST_ROOTS_B: begin
					pw_q <= mul_acc_q;
					st_q <= st_q - ntt_pkg::LG_W'(1);
					state_q <= ST_ROOTS;
				end
				ST_REV: begin
					if (i_q < rev_j) begin
						state_q <= ST_REV_B;
					end else if (i_q == mask) begin
						st_q <= ntt_pkg::LG_W'(1);
						base_q <= '0;
						j_q <= '0;
						w_q <= 31'd1;
						state_q <= ST_BF;
					end else begin
						i_q <= i_q + ntt_pkg::ADDR_W'(1);
					end
				end
				ST_REV_B: begin
					t_q <= ram_rdata;
					state_q <= ST_REV_C;
				end
				ST_REV_C: state_q <= ST_REV_D;
				ST_REV_D: begin
					if (i_q == mask) begin
						st_q <= ntt_pkg::LG_W'(1);
						base_q <= '0;
						j_q <= '0;
						w_q <= 31'd1;
						state_q <= ST_BF;
					end else begin
						i_q <= i_q + ntt_pkg::ADDR_W'(1);
						state_q <= ST_REV;
					end
				end
				ST_BF: state_q <= ST_BF_A;
				ST_BF_A: begin
					v_q <= ram_rdata;
					state_q <= ST_BF_B;
				end
				ST_BF_B: begin
					u_q <= ram_rdata;
					ret_q <= ST_BF_C;
					state_q <= ST_MUL;
				end
				ST_BF_C: begin
					v_q <= mul_acc_q;
					state_q <= ST_BF_D;
				end
				ST_BF_D: begin
					if (!last_j) begin
						j_q <= j_q + CW'(1);
						ret_q <= ST_BF_W;
						state_q <= ST_MUL;
					end else begin
						j_q <= '0;
						w_q <= 31'd1;
						if (base_nxt != n_full) begin
							base_q <= base_nxt;
							state_q <= ST_BF;
						end else if (st_q != lg) begin
							st_q <= st_q + ntt_pkg::LG_W'(1);
							base_q <= '0;
							state_q <= ST_BF;
						end else if (inverse_mode_q) begin
							i_q <= '0;
							state_q <= ST_SC;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_BF_W: begin
					w_q <= mul_acc_q;
					state_q <= ST_BF;
				end
				ST_SC: state_q <= ST_SC_A;
				ST_SC_A: begin
					ret_q <= ST_SC_B;
					state_q <= ST_MUL;
				end
				ST_SC_B: begin
					if (i_q == mask) begin
						state_q <= ST_DONE;
					end else begin
						i_q <= i_q + ntt_pkg::ADDR_W'(1);
						state_q <= ST_SC;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_MUL: begin
					if (mul_cnt_q == '0) begin
						state_q <= ret_q;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`NTT_ASSERT_NOW(a_take_idle, !cmd_stall, state_q == ST_IDLE, "request taken while busy")
	`NTT_ASSERT_NOW(a_mul_owned, mul_cnt_q != '0, state_q == ST_MUL, "multiplier runs unwatched")
	`NTT_ASSERT_NEXT(a_read_wait, accept && op == ntt_pkg::OP_READ, state_q == ST_RD_WAIT,
		"read did not wait for ram")
	`NTT_ASSERT_NOW(a_read_slot, state_q == ST_RD_WAIT, !out_valid_q, "read reply slot busy")

endmodule
